### hdl/point_to_line_distance_unit_assert.svh
// Assertion macros for the port checker of the distance unit.
`ifndef POINT_TO_LINE_DISTANCE_UNIT_ASSERT_SVH
`define POINT_TO_LINE_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is high
`define P2L_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define P2L_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// what must hold in the cycle after reset
`define P2L_ASSERT_RESET(name, cons, msg) \
   name: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

### hdl/p2l_pkg.sv
// ----------------------------------------------------------------------------
// p2l_pkg
// Shared constants and cell data types of the point-to-line distance unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package p2l_pkg;

   localparam int CoordWidth    = 32;
   localparam int FracBits      = 16;
   localparam int CsrIndexWidth = 3;
   localparam int DivSteps      = 32;
   localparam int SqrtSteps     = 31;
   localparam int Latency       = 76;

   localparam logic [31:0] FixOne = 32'h0001_0000;
   localparam logic [31:0] PosMax = 32'h7FFF_FFFF;
   localparam logic [31:0] NegMax = 32'h8000_0000;

   localparam logic [CsrIndexWidth-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_DIR_Z    = 3'd5;

   // one restoring division step: partial remainder, dividend bits still to
   // shift in, quotient bits so far
   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
   } div_type;

   // one digit-by-digit square root step
   typedef struct packed {
      logic [61:0] rad;
      logic [32:0] rem;
      logic [30:0] root;
   } sqrt_type;

endpackage

`default_nettype wire

### hdl/p2l_div_cell.sv
// ----------------------------------------------------------------------------
// p2l_div_cell
// One quotient bit of the unsigned restoring divider chain, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2l_div_cell (
   input  logic              clock,
   input  logic              en,
   input  logic [63:0]       den,
   input  p2l_pkg::div_type  up_data,
   output p2l_pkg::div_type  dn_data
);
   import p2l_pkg::*;

   logic [64:0] trial;
   logic [64:0] rest;
   logic        take;
   div_type     step_in;
   div_type     step_ff;

   always_comb begin
      trial        = {up_data.rem, up_data.low[31]};
      rest         = trial - {1'b0, den};
      take         = (trial >= {1'b0, den});
      step_in.rem  = take ? rest[63:0] : trial[63:0];
      step_in.low  = {up_data.low[30:0], 1'b0};
      step_in.quo  = {up_data.quo[30:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign dn_data = step_ff;

endmodule

`default_nettype wire

### hdl/p2l_sqrt_cell.sv
// ----------------------------------------------------------------------------
// p2l_sqrt_cell
// One root bit of the integer square root chain, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2l_sqrt_cell (
   input  logic               clock,
   input  logic               en,
   input  p2l_pkg::sqrt_type  up_data,
   output p2l_pkg::sqrt_type  dn_data
);
   import p2l_pkg::*;

   logic [34:0] part;
   logic [34:0] trial;
   logic [34:0] rest;
   logic        take;
   sqrt_type    step_in;
   sqrt_type    step_ff;

   always_comb begin
      part          = {up_data.rem, up_data.rad[61:60]};
      trial         = {2'b00, up_data.root, 2'b01};
      rest          = part - trial;
      take          = (part >= trial);
      step_in.rem   = take ? rest[32:0] : part[32:0];
      step_in.rad   = {up_data.rad[59:0], 2'b00};
      step_in.root  = {up_data.root[29:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign dn_data = step_ff;

endmodule

`default_nettype wire

### hdl/point_to_line_distance_unit.sv
// ----------------------------------------------------------------------------
// point_to_line_distance_unit
// Streams 3D point queries against a line held in registers: the line point
// at a given parameter, the parameter of the nearest line point and the
// distance to it, signed Q16.16 with saturation, the distance unsigned Q15.16.
// The unit takes one query transfer per clock unless a result is held.
// Its depth is set by the 32-cell divider chain (one quotient bit per cell)
// and the 31-cell square root chain (one root bit per cell), plus 13 stages
// of multiply, sum and clip logic around them. The whole pipeline advances
// together, so a stalled result holds every stage and req_stall follows
// rsp_stall while a result waits. The user must write the line registers
// through the csr port only while no query is in flight; the unit does not
// enforce it. dd_ff and then den_ff derive the squared direction length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_to_line_distance_unit (
   input  logic                                clock,
   input  logic                                reset,
   // query channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [31:0]                  req_point_x,
   input  logic signed [31:0]                  req_point_y,
   input  logic signed [31:0]                  req_point_z,
   input  logic signed [31:0]                  req_line_param,
   // line registers
   input  logic                                csr_we,
   input  logic [p2l_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [31:0]                         csr_wdata,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_on_line_x,
   output logic signed [31:0]                  rsp_on_line_y,
   output logic signed [31:0]                  rsp_on_line_z,
   output logic signed [31:0]                  rsp_nearest_param,
   output logic [30:0]                         rsp_distance_out,
   output logic                                rsp_degenerate,
   output logic                                rsp_saturated
);
   import p2l_pkg::*;

   // side data riding along the divider chain
   typedef struct packed {
      logic [2:0][31:0] on;
      logic [2:0][32:0] diff;
      logic             sat;
      logic             neg;
      logic             deg;
      logic             ovf;
   } front_type;

   // side data from the quotient onward
   typedef struct packed {
      logic [2:0][31:0] on;
      logic [31:0]      u0;
      logic             deg;
      logic             sat;
   } back_type;

   typedef struct packed {
      back_type side;
      logic     dsat;
   } tail_type;

   // ---------------------------------------------------------------------
   // Handshake: all stages move together unless the output is held.
   // ---------------------------------------------------------------------
   logic                adv;
   logic                req_accept;
   logic [Latency-1:0]  valid_ff;
   logic [Latency-1:0]  valid_in;

   assign adv        = !(valid_ff[Latency-1] && rsp_stall);
   assign req_stall  = !adv;
   assign req_accept = req_valid && adv;
   assign valid_in   = {valid_ff[Latency-2:0], req_accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line registers and squared direction length
   // ---------------------------------------------------------------------
   logic signed [31:0] origin_ff [3];
   logic signed [31:0] dir_ff [3];
   logic [63:0]        dd_ff [3];
   logic [63:0]        den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= FixOne;
         dir_ff[2]    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X: origin_ff[0] <= csr_wdata;
            REG_ORIGIN_Y: origin_ff[1] <= csr_wdata;
            REG_ORIGIN_Z: origin_ff[2] <= csr_wdata;
            REG_DIR_X:    dir_ff[0]    <= csr_wdata;
            REG_DIR_Y:    dir_ff[1]    <= csr_wdata;
            REG_DIR_Z:    dir_ff[2]    <= csr_wdata;
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dd_ff[i] <= dir_ff[i] * dir_ff[i];
      end
      den_ff <= dd_ff[0] + dd_ff[1] + dd_ff[2];
   end

   // ---------------------------------------------------------------------
   // Stage 1: P - O and u * d
   // ---------------------------------------------------------------------
   logic signed [31:0] point [3];
   logic signed [32:0] s1_diff_ff [3];
   logic signed [63:0] s1_ud_ff [3];

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s1_diff_ff[i] <= point[i] - origin_ff[i];
            s1_ud_ff[i]   <= req_line_param * dir_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: line point O + floor(u * d), clipped; d * (P - O) terms
   // ---------------------------------------------------------------------
   logic signed [48:0] on_sum [3];
   logic [2:0][31:0]   on_clip;
   logic [2:0]         on_sat;
   logic [2:0][31:0]   s2_on_ff;
   logic               s2_sat_ff;
   logic [2:0][32:0]   s2_diff_ff;
   logic signed [64:0] s2_nd_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         on_sum[i] = $signed(s1_ud_ff[i][63:16]) + origin_ff[i];
         on_sat[i] = 1'b0;
         on_clip[i] = on_sum[i][31:0];
         if (!on_sum[i][48] && (|on_sum[i][47:31])) begin
            on_clip[i] = PosMax;
            on_sat[i]  = 1'b1;
         end else if (on_sum[i][48] && !(&on_sum[i][47:31])) begin
            on_clip[i] = NegMax;
            on_sat[i]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_on_ff  <= on_clip;
         s2_sat_ff <= |on_sat;
         for (int i = 0; i < 3; i++) begin
            s2_diff_ff[i] <= s1_diff_ff[i];
            s2_nd_ff[i]   <= dir_ff[i] * s1_diff_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: numerator d.(P - O)
   // Stage 4: sign and magnitude, degenerate check
   // ---------------------------------------------------------------------
   logic signed [66:0] s3_num_ff;
   logic [2:0][31:0]   s3_on_ff;
   logic               s3_sat_ff;
   logic [2:0][32:0]   s3_diff_ff;
   logic [66:0]        s4_mag_ff;
   logic               s4_neg_ff;
   logic               s4_deg_ff;
   logic [2:0][31:0]   s4_on_ff;
   logic               s4_sat_ff;
   logic [2:0][32:0]   s4_diff_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_num_ff  <= s2_nd_ff[0] + s2_nd_ff[1] + s2_nd_ff[2];
         s3_on_ff   <= s2_on_ff;
         s3_sat_ff  <= s2_sat_ff;
         s3_diff_ff <= s2_diff_ff;
         s4_mag_ff  <= s3_num_ff[66] ? 67'(-s3_num_ff) : 67'(s3_num_ff);
         s4_neg_ff  <= s3_num_ff[66];
         s4_deg_ff  <= (den_ff == '0);
         s4_on_ff   <= s3_on_ff;
         s4_sat_ff  <= s3_sat_ff;
         s4_diff_ff <= s3_diff_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Divider chain: |num| * 2^16 / d.d. The upper dividend bits preload the
   // remainder; if they already reach d.d the quotient needs more than 32
   // bits and is clipped.
   // ---------------------------------------------------------------------
   div_type   div_link [DivSteps+1];
   front_type front_side;
   front_type dside_ff [DivSteps];

   always_comb begin
      div_link[0].rem = 64'(s4_mag_ff[66:16]);
      div_link[0].low = {s4_mag_ff[15:0], 16'h0000};
      div_link[0].quo = '0;
      front_side.on   = s4_on_ff;
      front_side.diff = s4_diff_ff;
      front_side.sat  = s4_sat_ff;
      front_side.neg  = s4_neg_ff;
      front_side.deg  = s4_deg_ff;
      front_side.ovf  = ({13'b0, s4_mag_ff[66:16]} >= den_ff);
   end

   for (genvar g = 0; g < DivSteps; g++) begin : g_div
      p2l_div_cell u_cell (
         .clock   (clock),
         .en      (adv),
         .den     (den_ff),
         .up_data (div_link[g]),
         .dn_data (div_link[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dside_ff[0] <= front_side;
         for (int j = 1; j < DivSteps; j++) begin
            dside_ff[j] <= dside_ff[j-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Quotient: sign, clip, degenerate override
   // ---------------------------------------------------------------------
   logic [31:0]      quo;
   front_type        div_side;
   logic [31:0]      u0_val;
   logic             u0_sat;
   back_type         u_side_ff;
   logic [2:0][32:0] u_diff_ff;

   assign quo      = div_link[DivSteps].quo;
   assign div_side = dside_ff[DivSteps-1];

   always_comb begin
      u0_val = '0;
      u0_sat = 1'b0;
      if (div_side.deg) begin
         u0_val = '0;
      end else if (div_side.ovf) begin
         u0_sat = 1'b1;
         u0_val = div_side.neg ? NegMax : PosMax;
      end else if (!div_side.neg) begin
         if (quo[31]) begin
            u0_sat = 1'b1;
            u0_val = PosMax;
         end else begin
            u0_val = quo;
         end
      end else if (quo > NegMax) begin
         u0_sat = 1'b1;
         u0_val = NegMax;
      end else begin
         u0_val = -quo;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_side_ff.on  <= div_side.on;
         u_side_ff.u0  <= u0_val;
         u_side_ff.deg <= div_side.deg;
         u_side_ff.sat <= div_side.sat | u0_sat;
         u_diff_ff     <= div_side.diff;
      end
   end

   // ---------------------------------------------------------------------
   // Residual r = (P - O) * 2^16 - u0 * d and its squared length.
   // Any |r| at or above 2^47 already puts the distance past full scale,
   // so squares work on 47-bit magnitudes split into 23-bit and 24-bit halves.
   // ---------------------------------------------------------------------
   logic signed [63:0] a_ud0_ff [3];
   logic [2:0][32:0]   a_diff_ff;
   back_type           a_side_ff;
   logic signed [65:0] b_r_ff [3];
   back_type           b_side_ff;
   logic [65:0]        r_mag [3];
   logic               r_big;
   logic [46:0]        c_a_ff [3];
   logic               c_big_ff;
   back_type           c_side_ff;
   logic [45:0]        d_hh_ff [3];
   logic [46:0]        d_hl_ff [3];
   logic [47:0]        d_ll_ff [3];
   logic               d_big_ff;
   back_type           d_side_ff;
   logic [93:0]        e_sq_ff [3];
   logic               e_big_ff;
   back_type           e_side_ff;
   logic [95:0]        f_s_ff;
   logic               f_big_ff;
   back_type           f_side_ff;
   logic [61:0]        g_rad_ff;
   logic               g_dsat_ff;
   back_type           g_side_ff;

   always_comb begin
      r_big = 1'b0;
      for (int i = 0; i < 3; i++) begin
         r_mag[i] = b_r_ff[i][65] ? 66'(-b_r_ff[i]) : 66'(b_r_ff[i]);
         r_big    = r_big | (|r_mag[i][65:47]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            a_ud0_ff[i] <= $signed(u_side_ff.u0) * dir_ff[i];
            b_r_ff[i]   <= ($signed(a_diff_ff[i]) <<< FracBits) - a_ud0_ff[i];
            c_a_ff[i]   <= r_mag[i][46:0];
            d_hh_ff[i]  <= c_a_ff[i][46:24] * c_a_ff[i][46:24];
            d_hl_ff[i]  <= c_a_ff[i][46:24] * c_a_ff[i][23:0];
            d_ll_ff[i]  <= c_a_ff[i][23:0] * c_a_ff[i][23:0];
            e_sq_ff[i]  <= (94'(d_hh_ff[i]) << 48) + (94'(d_hl_ff[i]) << 25)
                           + 94'(d_ll_ff[i]);
         end
         a_diff_ff <= u_diff_ff;
         a_side_ff <= u_side_ff;
         b_side_ff <= a_side_ff;
         c_big_ff  <= r_big;
         c_side_ff <= b_side_ff;
         d_big_ff  <= c_big_ff;
         d_side_ff <= c_side_ff;
         e_big_ff  <= d_big_ff;
         e_side_ff <= d_side_ff;
         f_s_ff    <= 96'(e_sq_ff[0]) + 96'(e_sq_ff[1]) + 96'(e_sq_ff[2]);
         f_big_ff  <= e_big_ff;
         f_side_ff <= e_side_ff;
         // floor(sqrt(s) / 2^16) is the root of s / 2^32
         g_rad_ff  <= f_s_ff[93:32];
         g_dsat_ff <= f_big_ff | (|f_s_ff[95:94]);
         g_side_ff <= f_side_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Square root chain
   // ---------------------------------------------------------------------
   sqrt_type sqrt_link [SqrtSteps+1];
   tail_type sside_ff [SqrtSteps];
   tail_type tail_out;

   always_comb begin
      sqrt_link[0].rad  = g_rad_ff;
      sqrt_link[0].rem  = '0;
      sqrt_link[0].root = '0;
   end

   for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
      p2l_sqrt_cell u_cell (
         .clock   (clock),
         .en      (adv),
         .up_data (sqrt_link[g]),
         .dn_data (sqrt_link[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sside_ff[0].side <= g_side_ff;
         sside_ff[0].dsat <= g_dsat_ff;
         for (int j = 1; j < SqrtSteps; j++) begin
            sside_ff[j] <= sside_ff[j-1];
         end
      end
   end

   assign tail_out = sside_ff[SqrtSteps-1];

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic [2:0][31:0] rsp_on_ff;
   logic [31:0]      rsp_u0_ff;
   logic [30:0]      rsp_dist_ff;
   logic             rsp_deg_ff;
   logic             rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_on_ff   <= tail_out.side.on;
         rsp_u0_ff   <= tail_out.side.u0;
         rsp_dist_ff <= tail_out.dsat ? PosMax[30:0] : sqrt_link[SqrtSteps].root;
         rsp_deg_ff  <= tail_out.side.deg;
         rsp_sat_ff  <= tail_out.side.sat | tail_out.dsat;
      end
   end

   assign rsp_valid         = valid_ff[Latency-1];
   assign rsp_on_line_x     = rsp_on_ff[0];
   assign rsp_on_line_y     = rsp_on_ff[1];
   assign rsp_on_line_z     = rsp_on_ff[2];
   assign rsp_nearest_param = rsp_u0_ff;
   assign rsp_distance_out  = rsp_dist_ff;
   assign rsp_degenerate    = rsp_deg_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule

`default_nettype wire

### hdl/p2l_checker.sv
// ----------------------------------------------------------------------------
// p2l_checker
// Port-level checks of the distance unit, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "point_to_line_distance_unit_assert.svh"

module p2l_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_on_line_x,
   input logic signed [31:0] rsp_on_line_y,
   input logic signed [31:0] rsp_on_line_z,
   input logic signed [31:0] rsp_nearest_param,
   input logic [30:0]        rsp_distance_out,
   input logic               rsp_degenerate,
   input logic               rsp_saturated
);

   // whole result payload as one word
   logic [160:0] rsp_word;

   assign rsp_word = {rsp_on_line_x, rsp_on_line_y, rsp_on_line_z, rsp_nearest_param,
                      rsp_distance_out, rsp_degenerate, rsp_saturated};

   // a held result keeps its payload
   `P2L_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "held result changed")

   // the query side only waits on a held result
   `P2L_ASSERT_IMPL(a_req_stall, 1'b1, req_stall == (rsp_valid && rsp_stall), "stray req_stall")

   // zero-length direction gives a zero nearest parameter
   `P2L_ASSERT_IMPL(a_deg_zero, rsp_valid && rsp_degenerate, rsp_nearest_param == '0, "degenerate u0")

   // pipeline empties on reset
   `P2L_ASSERT_RESET(a_reset_empty, !rsp_valid, "result valid after reset")

endmodule

bind point_to_line_distance_unit p2l_checker u_checker (.*);

`default_nettype wire

### tb/point_to_line_distance_checker.sv
// ----------------------------------------------------------------------------
// point_to_line_distance_checker
// Watches the query, result and line-register ports of the distance unit,
// predicts each result with wide exact arithmetic and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_to_line_distance_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_line_param,
   input  logic               csr_we,
   input  logic [p2l_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_on_line_x,
   input  logic signed [31:0] rsp_on_line_y,
   input  logic signed [31:0] rsp_on_line_z,
   input  logic signed [31:0] rsp_nearest_param,
   input  logic [30:0]        rsp_distance_out,
   input  logic               rsp_degenerate,
   input  logic               rsp_saturated,
   output int                 mismatch_count,
   output int                 pending_count
);
   import p2l_pkg::*;

   typedef logic signed [159:0] wide_t;

   typedef struct {
      logic signed [31:0] on_x, on_y, on_z, near_u;
      logic [30:0]        distance;
      logic               degen, sat;
   } line_result_t;

   logic signed [31:0] line_org [3];
   logic signed [31:0] line_dir [3];
   line_result_t       expected_results [$];

   function automatic logic signed [31:0] clip_word(input wide_t v, output bit hit);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< 31) - 1;
      lo = -(wide_t'(1) <<< 31);
      hit = 1'b0;
      if (v > hi) begin
         hit = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < lo) begin
         hit = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [159:0] floor_sqrt(input logic [159:0] n);
      logic [159:0] root, b;
      root = '0;
      b = 160'd1 << 158;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic line_result_t predict_distance(input logic signed [31:0] pt [3],
                                                     input logic signed [31:0] u);
      line_result_t r;
      wide_t        diff [3];
      wide_t        num, den, u0, resid, sq;
      logic [159:0] root;
      logic signed [31:0] on [3];
      bit           hit, sat;
      sat = 1'b0;
      num = '0;
      den = '0;
      for (int i = 0; i < 3; i++) begin
         on[i] = clip_word(wide_t'(line_org[i]) + ((wide_t'(u) * wide_t'(line_dir[i])) >>> 16),
                           hit);
         sat |= hit;
         diff[i] = wide_t'(pt[i]) - wide_t'(line_org[i]);
         num += wide_t'(line_dir[i]) * diff[i];
         den += wide_t'(line_dir[i]) * wide_t'(line_dir[i]);
      end
      r.degen = (den == 0);
      if (r.degen) begin
         u0 = '0;
      end else begin
         u0 = (num <<< 16) / den;   // signed divide truncates toward zero
         u0 = wide_t'(clip_word(u0, hit));
         sat |= hit;
      end
      sq = '0;
      for (int i = 0; i < 3; i++) begin
         resid = (diff[i] <<< 16) - u0 * wide_t'(line_dir[i]);
         sq += resid * resid;
      end
      root = floor_sqrt(sq) >> 16;
      if (root > 160'h7FFF_FFFF) begin
         root = 160'h7FFF_FFFF;
         sat = 1'b1;
      end
      r.on_x = on[0];
      r.on_y = on[1];
      r.on_z = on[2];
      r.near_u = u0[31:0];
      r.distance = root[30:0];
      r.sat = sat;
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      line_result_t       exp_r;
      logic signed [31:0] pt [3];
      if (reset) begin
         line_org[0] = '0; line_org[1] = '0; line_org[2] = '0;
         line_dir[0] = '0; line_dir[1] = FixOne; line_dir[2] = '0;
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         // register writes land at this edge, before a query taken at the same edge
         if (csr_we) begin
            case (csr_index)
               REG_ORIGIN_X: line_org[0] = csr_wdata;
               REG_ORIGIN_Y: line_org[1] = csr_wdata;
               REG_ORIGIN_Z: line_org[2] = csr_wdata;
               REG_DIR_X:    line_dir[0] = csr_wdata;
               REG_DIR_Y:    line_dir[1] = csr_wdata;
               REG_DIR_Z:    line_dir[2] = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            pt[0] = req_point_x;
            pt[1] = req_point_y;
            pt[2] = req_point_z;
            expected_results.push_back(predict_distance(pt, req_line_param));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result transfer with nothing expected at %0t", $realtime);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_on_line_x !== exp_r.on_x || rsp_on_line_y !== exp_r.on_y ||
                   rsp_on_line_z !== exp_r.on_z || rsp_nearest_param !== exp_r.near_u ||
                   rsp_distance_out !== exp_r.distance || rsp_degenerate !== exp_r.degen ||
                   rsp_saturated !== exp_r.sat) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch at %0t", $realtime);
                     $display("  exp on=(%h %h %h) u0=%h dist=%h deg=%b sat=%b",
                              exp_r.on_x, exp_r.on_y, exp_r.on_z, exp_r.near_u,
                              exp_r.distance, exp_r.degen, exp_r.sat);
                     $display("  got on=(%h %h %h) u0=%h dist=%h deg=%b sat=%b",
                              rsp_on_line_x, rsp_on_line_y, rsp_on_line_z,
                              rsp_nearest_param, rsp_distance_out, rsp_degenerate,
                              rsp_saturated);
                  end
               end
            end
         end
      end
   end

endmodule

### tb/tb_point_to_line_distance_unit.sv
// ----------------------------------------------------------------------------
// tb_point_to_line_distance_unit
// Drives the distance unit with directed corner queries and then random
// phases under varying line settings, with random gaps and result stalls.
// The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_point_to_line_distance_unit;
   import p2l_pkg::*;

   localparam logic [CsrIndexWidth-1:0] RegUnused = 3'd6;  // outside the map
   localparam int CycleLimit   = 2_000_000;
   localparam int RandomPhases = 10;
   localparam int PhaseItems   = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic signed [31:0] req_line_param = '0;
   logic               csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [31:0]        csr_wdata = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_on_line_x, rsp_on_line_y, rsp_on_line_z, rsp_nearest_param;
   logic [30:0]        rsp_distance_out;
   logic               rsp_degenerate, rsp_saturated;

   int mismatch_count, pending_count;
   int cycle_count = 0;
   int query_count = 0;
   int degenerate_lines = 0;
   // idling knobs: gaps on the query side, stall odds on the result side
   bit idle_on = 1'b1;
   int stall_pct = 20;
   int stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   point_to_line_distance_unit u_dut (.*);

   point_to_line_distance_checker u_checker (.*);

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // result-side stall: mostly short bursts, now and then a long one
   always @(negedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int gap_len();
      int pick;
      if (!idle_on) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // coordinate pick: full range, small magnitude, or an extreme value
   function automatic logic signed [31:0] pick_coord(input int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
         default:
            case ($urandom_range(0, 5))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0000_0000;
               3: return 32'sh0001_0000;
               4: return -32'sh0001_0000;
               default: return 32'sh0000_0001;
            endcase
      endcase
   endfunction

   task automatic send_query(input logic signed [31:0] px, py, pz, u);
      int gap;
      req_point_x    <= px;
      req_point_y    <= py;
      req_point_z    <= pz;
      req_line_param <= u;
      req_valid      <= 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      query_count++;
      @(negedge clock);
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // write enable stays high across a run of writes; the caller drops it
   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   // drain the pipe, then rewrite the whole line
   task automatic load_line(input logic signed [31:0] ox, oy, oz, dx, dy, dz);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_ORIGIN_Z, oz);
      write_reg(REG_DIR_X, dx);
      write_reg(REG_DIR_Y, dy);
      write_reg(REG_DIR_Z, dz);
      if ($urandom_range(0, 2) == 0) write_reg(RegUnused, $urandom);
      csr_we <= 1'b0;
      // squared length settles through dd_ff and den_ff after the last write
      repeat (4) @(negedge clock);
      if (dx == 0 && dy == 0 && dz == 0) degenerate_lines++;
   endtask

   initial begin
      int mode, pmode;
      logic signed [31:0] d [3];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset line along y, then corner lines
      send_query('0, '0, '0, '0);
      send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_query(32'sh0003_0000, -32'sh0002_0000, 32'sh0004_0000, 32'sh0000_8000);
      // degenerate direction: u0 is zero, distance is to the origin
      load_line(32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000, '0, '0, '0);
      send_query(32'sh0004_0000, 32'sh0006_0000, 32'sh0002_0000, 32'sh0001_0000);
      send_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      // tiny direction: nearest parameter clips both ways
      load_line('0, '0, '0, 32'sh0000_0001, '0, '0);
      send_query(32'sh7FFF_FFFF, '0, '0, 32'sh7FFF_FFFF);
      send_query(32'sh8000_0000, '0, '0, 32'sh8000_0000);
      send_query('0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0);
      // huge line: on-line point and distance clip
      load_line(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
      send_query('0, '0, '0, '0);
      load_line(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_query(32'sh8000_0000, '0, 32'sh7FFF_FFFF, -32'sh0001_0000);
      // plain unit line along x, point off it
      load_line('0, '0, '0, 32'sh0001_0000, '0, '0);
      send_query(32'sh0005_0000, 32'sh0003_0000, 32'sh0004_0000, 32'sh0002_0000);
      send_query(-32'sh0005_8000, -32'sh0000_0001, 32'sh0000_0001, -32'sh0002_0000);

      // random phases under changing lines and idling
      for (int ph = 0; ph < RandomPhases; ph++) begin
         mode = ph % 4;
         for (int i = 0; i < 3; i++)
            d[i] = (mode == 3) ? '0 : pick_coord(mode == 2 ? 2 : $urandom_range(0, 1));
         load_line(pick_coord(mode == 2 ? 2 : $urandom_range(0, 1)),
                   pick_coord(mode == 2 ? 2 : $urandom_range(0, 1)),
                   pick_coord(mode == 2 ? 2 : $urandom_range(0, 1)), d[0], d[1], d[2]);
         idle_on   = (ph % 5 != 4);   // some phases run back to back
         stall_pct = $urandom_range(5, 40);
         for (int i = 0; i < PhaseItems; i++) begin
            pmode = ($urandom_range(0, 9) < 4) ? 1 : ($urandom_range(0, 9) == 0 ? 2 : 0);
            send_query(pick_coord(pmode), pick_coord(pmode), pick_coord(pmode),
                       pick_coord(pmode));
         end
      end
      idle_on = 1'b1;
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (Latency + 20) @(negedge clock);

      $display("%0d queries over %0d random line settings, %0d degenerate lines",
               query_count, RandomPhases, degenerate_lines);
      $display("%0d cycles with random gaps and result stalls", cycle_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pending_count);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
